// ===== rtl/plom_pkg.sv =====
// Shared constants and field layout for the piecewise linear opacity map.
package plom_pkg;

	// table geometry
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 5;

	// field widths
	localparam int POS_W   = 32;
	localparam int OPA_W   = 16;
	localparam int ENTRY_W = POS_W + OPA_W;
	localparam int PROD_W  = POS_W + OPA_W;
	localparam int DIVC_W  = $clog2(OPA_W);

	// stream payload layout
	localparam int TDATA_FIELDS_W = IDX_W + POS_W + OPA_W + POS_W;
	localparam int S_TDATA_W      = ((TDATA_FIELDS_W + 7) / 8) * 8;
	localparam int S_TUSER_W      = 2;
	localparam int M_TDATA_W      = OPA_W;

	localparam logic [CNT_W-1:0] NUM_POINTS_RST = CNT_W'(2);

	// item kinds carried in tuser bit 0
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_MAP  = 1'b1;

endpackage

// ===== rtl/plom_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module plom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/piecewise_linear_opacity_map.sv =====
// Piecewise linear opacity map: control point table, search sequencer and serial divider.
//
// Input stream (s_axis_*): one transaction is either a load of one control point
// (tuser bit 0 clear) or a position to map (tuser bit 0 set). Loads write the
// table and give no result; map transactions give exactly one result on the
// output stream (m_axis_*), with tlast echoed from the input.
// Configuration channel (cfg_*): writes the number of control points in use;
// it is always ready and should only be written while the block is idle.
// Sequencing: a load is written when it is accepted. A map item is held for its whole work:
//   invalid position: straight to the result register;
//   below first / above last point: the first-point check, then the last-point check;
//   interpolation: both checks, table reads up to the first point above the
//   position, a multiply step, the divider steps and a final add.
// The single-port table read and the one-bit-per-cycle restoring divider set
// the length of this work.
// s_axis_tready is high only while the sequencer is idle. A result sits in
// the output register until taken; a stalled receiver holds the block.
// Reset: control state clears, the point count returns to 2; the table is not
// cleared and must be loaded before use.
module piecewise_linear_opacity_map (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: point_index, point_position, point_opacity, position, zero pad
	input  logic [plom_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// tuser: func, position_valid
	input  logic [plom_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input  logic                          s_axis_tlast,
	// output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: opacity
	output logic [plom_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [plom_pkg::CNT_W-1:0]    cfg_data
);

	import plom_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHKL,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    num_points_q;
	logic signed [POS_W-1:0] p_q;
	logic                last_q;
	logic signed [POS_W-1:0] prev_x_q;
	logic [OPA_W-1:0]    prev_o_q;
	logic [IDX_W-1:0]    j_q;
	logic [POS_W-1:0]    d_q;
	logic [POS_W-1:0]    dx_q;
	logic [OPA_W-1:0]    mag_q;
	logic                neg_q;
	logic [POS_W-1:0]    rem_q;
	logic [OPA_W-1:0]    quo_q;
	logic [DIVC_W-1:0]   cnt_q;
	logic [OPA_W-1:0]    opacity_q;

	// input fields
	logic [IDX_W-1:0]        in_index;
	logic [POS_W-1:0]        in_point_pos;
	logic [OPA_W-1:0]        in_point_opa;
	logic signed [POS_W-1:0] in_pos;
	logic                    in_func;
	logic                    in_pos_valid;
	logic                    in_accept;

	assign in_index     = s_axis_tdata[IDX_W-1:0];
	assign in_point_pos = s_axis_tdata[IDX_W +: POS_W];
	assign in_point_opa = s_axis_tdata[IDX_W+POS_W +: OPA_W];
	assign in_pos       = s_axis_tdata[IDX_W+POS_W+OPA_W +: POS_W];
	assign in_func      = s_axis_tuser[0];
	assign in_pos_valid = s_axis_tuser[1];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// index of the last point in use
	logic [IDX_W-1:0] last_idx;
	always_comb begin
		if (num_points_q == '0) begin
			last_idx = '0;
		end else if (num_points_q > CNT_W'(MAX_POINTS)) begin
			last_idx = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = IDX_W'(num_points_q - CNT_W'(1));
		end
	end

	// table read address, one step ahead of the sequencer
	logic [IDX_W-1:0] rd_addr;
	always_comb begin
		case (state_q)
			ST_CHK0: rd_addr = last_idx;
			ST_CHKL: rd_addr = IDX_W'(1);
			ST_SCAN: rd_addr = j_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	logic [ENTRY_W-1:0] rd_entry;
	logic signed [POS_W-1:0] ent_x;
	logic [OPA_W-1:0]        ent_o;

	plom_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (in_accept && (in_func == FUNC_LOAD)),
		.waddr(in_index),
		.wdata({in_point_pos, in_point_opa}),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	assign ent_x = rd_entry[OPA_W +: POS_W];
	assign ent_o = rd_entry[OPA_W-1:0];

	// segment set-up: offsets and opacity step
	logic [POS_W:0]   d_full;
	logic [POS_W:0]   dx_full;
	logic [OPA_W:0]   diff;
	logic [OPA_W:0]   diff_abs;
	assign d_full   = {p_q[POS_W-1], p_q} - {prev_x_q[POS_W-1], prev_x_q};
	assign dx_full  = {ent_x[POS_W-1], ent_x} - {prev_x_q[POS_W-1], prev_x_q};
	assign diff     = {1'b0, ent_o} - {1'b0, prev_o_q};
	assign diff_abs = diff[OPA_W] ? (~diff + (OPA_W+1)'(1)) : diff;

	// product of step and offset
	logic [PROD_W-1:0] prod;
	assign prod = PROD_W'(mag_q) * PROD_W'(d_q);

	// one restoring division step
	logic [POS_W:0] div_t;
	logic           div_ge;
	assign div_t  = {rem_q, quo_q[OPA_W-1]};
	assign div_ge = (div_t >= {1'b0, dx_q});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_points_q <= NUM_POINTS_RST;
			p_q          <= '0;
			last_q       <= 1'b0;
			prev_x_q     <= '0;
			prev_o_q     <= '0;
			j_q          <= '0;
			d_q          <= '0;
			dx_q         <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			rem_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			opacity_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_points_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_func == FUNC_MAP)) begin
						p_q    <= in_pos;
						last_q <= s_axis_tlast;
						if (!in_pos_valid) begin
							opacity_q <= '0;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_CHK0;
						end
					end
				end
				// first point: clamp below
				ST_CHK0: begin
					if (p_q <= ent_x) begin
						opacity_q <= ent_o;
						state_q   <= ST_OUT;
					end else begin
						prev_x_q <= ent_x;
						prev_o_q <= ent_o;
						state_q  <= ST_CHKL;
					end
				end
				// last point: clamp above
				ST_CHKL: begin
					if (p_q >= ent_x) begin
						opacity_q <= ent_o;
						state_q   <= ST_OUT;
					end else begin
						j_q     <= IDX_W'(1);
						state_q <= ST_SCAN;
					end
				end
				// find first point above the position
				ST_SCAN: begin
					if (p_q < ent_x) begin
						if (ent_x <= prev_x_q) begin
							opacity_q <= prev_o_q;
							state_q   <= ST_OUT;
						end else begin
							d_q     <= d_full[POS_W-1:0];
							dx_q    <= dx_full[POS_W-1:0];
							mag_q   <= diff_abs[OPA_W-1:0];
							neg_q   <= diff[OPA_W];
							state_q <= ST_MUL;
						end
					end else begin
						prev_x_q <= ent_x;
						prev_o_q <= ent_o;
						j_q      <= j_q + IDX_W'(1);
					end
				end
				// quotient fits the opacity width, so the product bits above it seed the remainder
				ST_MUL: begin
					rem_q   <= prod[PROD_W-1:OPA_W];
					quo_q   <= prod[OPA_W-1:0];
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= div_ge ? POS_W'(div_t - {1'b0, dx_q}) : div_t[POS_W-1:0];
					quo_q <= {quo_q[OPA_W-2:0], div_ge};
					cnt_q <= cnt_q + DIVC_W'(1);
					if (cnt_q == DIVC_W'(OPA_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					opacity_q <= neg_q ? (prev_o_q - quo_q) : (prev_o_q + quo_q);
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = opacity_q;
	assign m_axis_tlast  = last_q;

endmodule

// ===== bench/piecewise_linear_opacity_map_tb.sv =====
// Self-checking testbench for the piecewise linear opacity map.
`timescale 1ns / 1ps

module piecewise_linear_opacity_map_tb;
	import plom_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int TAIL_CYCLES     = 48;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int MAPS_PER_PHASE  = 80;
	localparam int NUM_PHASES      = 10;

	// one input transaction, fields unpacked
	typedef struct {
		logic                    func;
		logic [IDX_W-1:0]        slot;
		logic signed [POS_W-1:0] pt_pos;
		logic [OPA_W-1:0]        pt_opa;
		logic signed [POS_W-1:0] pos;
		logic                    pos_ok;
		logic                    tail;
	} lut_item_t;

	typedef struct {
		logic [OPA_W-1:0] opacity;
		logic             tail;
	} opacity_result_t;

	// Scoreboard: own copy of the table and point count, predicts opacities
	class opacity_scoreboard;
		logic signed [POS_W-1:0] tbl_pos [MAX_POINTS];
		logic [OPA_W-1:0]        tbl_opa [MAX_POINTS];
		logic [CNT_W-1:0]        point_count;
		opacity_result_t         expected_q [$];
		int                      errors;

		function new();
			point_count = NUM_POINTS_RST;
			errors = 0;
			foreach (tbl_pos[i]) begin
				tbl_pos[i] = '0;
				tbl_opa[i] = '0;
			end
		endfunction

		function void set_point_count(logic [CNT_W-1:0] n);
			point_count = n;
		endfunction

		// zero counts as one point, anything above the table size saturates
		function int points_in_use();
			if (point_count == 0)
				return 1;
			if (point_count > MAX_POINTS)
				return MAX_POINTS;
			return int'(point_count);
		endfunction

		function logic [OPA_W-1:0] map_opacity(logic signed [POS_W-1:0] p);
			int     hi;
			int     j;
			longint x0, x1, o0, o1, q;
			hi = points_in_use() - 1;
			if (p <= tbl_pos[0])
				return tbl_opa[0];
			if (p >= tbl_pos[hi])
				return tbl_opa[hi];
			// first point strictly above the position
			j = 1;
			while (j < hi && p >= tbl_pos[j])
				j++;
			x0 = tbl_pos[j-1];
			x1 = tbl_pos[j];
			o0 = longint'(tbl_opa[j-1]);
			o1 = longint'(tbl_opa[j]);
			if (x1 <= x0)
				return tbl_opa[j-1];
			q = ((o1 - o0) * (longint'(p) - x0)) / (x1 - x0);
			return OPA_W'(o0 + q);
		endfunction

		function void note_input(lut_item_t it);
			opacity_result_t r;
			if (it.func == FUNC_LOAD) begin
				tbl_pos[it.slot] = it.pt_pos;
				tbl_opa[it.slot] = it.pt_opa;
			end else begin
				r.opacity = it.pos_ok ? map_opacity(it.pos) : '0;
				r.tail    = it.tail;
				expected_q.push_back(r);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [OPA_W-1:0] opacity, logic tail);
			opacity_result_t r;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result opacity=%h last=%b", opacity, tail));
			end else begin
				r = expected_q.pop_front();
				if (opacity !== r.opacity)
					report($sformatf("opacity %h, predicted %h", opacity, r.opacity));
				if (tail !== r.tail)
					report($sformatf("tlast %b, predicted %b", tail, r.tail));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data;

	opacity_scoreboard model;
	int                burst_left = 0;
	int                rx_mode = 0;
	int                rx_left = 0;
	int                cycle_count = 0;

	piecewise_linear_opacity_map DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: check accepted results, then pick next tready from the stall pattern
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			model.check_result(m_axis_tdata, m_axis_tlast);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 80);
		end
		rx_left--;
		case (rx_mode)
			0: begin
				m_axis_tready <= 1'b1;
			end
			1: begin
				m_axis_tready <= 1'($urandom_range(0, 1));
			end
			2: begin
				m_axis_tready <= (rx_left % 4 == 0);
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	function automatic lut_item_t make_load(logic [IDX_W-1:0] slot,
			logic signed [POS_W-1:0] pt_pos, logic [OPA_W-1:0] pt_opa);
		lut_item_t it;
		it.func   = FUNC_LOAD;
		it.slot   = slot;
		it.pt_pos = pt_pos;
		it.pt_opa = pt_opa;
		it.pos    = $urandom;
		it.pos_ok = 1'($urandom_range(0, 1));
		it.tail   = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic lut_item_t make_map(logic signed [POS_W-1:0] pos, logic pos_ok,
			logic tail);
		lut_item_t it;
		it.func   = FUNC_MAP;
		it.slot   = IDX_W'($urandom_range(0, MAX_POINTS - 1));
		it.pt_pos = $urandom;
		it.pt_opa = OPA_W'($urandom);
		it.pos    = pos;
		it.pos_ok = pos_ok;
		it.tail   = tail;
		return it;
	endfunction

	// positions that land on, beside and between the loaded points, at the extremes, or random
	function automatic logic signed [POS_W-1:0] pick_position(int n);
		int     a;
		longint lo, hi;
		a  = $urandom_range(0, n - 1);
		lo = model.tbl_pos[a];
		hi = (a + 1 < n) ? longint'(model.tbl_pos[a+1]) : lo;
		case ($urandom_range(0, 9))
			0, 1: return model.tbl_pos[a];
			2: return model.tbl_pos[a] + 1;
			3: return model.tbl_pos[a] - 1;
			4, 5, 6: begin
				if (hi > lo)
					return POS_W'(lo + longint'($urandom) % (hi - lo));
				return $urandom;
			end
			7: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// sender: bursts of random length separated by random gaps
	task automatic send_item(input lut_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_TDATA_W - TDATA_FIELDS_W){1'b0}},
			it.pos, it.pt_opa, it.pt_pos, it.slot};
		s_axis_tuser  <= {it.pos_ok, it.func};
		s_axis_tlast  <= it.tail;
		do @(posedge clk); while (!s_axis_tready);
		model.note_input(it);
	endtask

	// wait for every pending result, then let a trailing load settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (model.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_point_count(input logic [CNT_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model.set_point_count(n);
	endtask

	// fill the slots in use, sorted or not, wide spread or tightly packed
	task automatic load_table(input int n, input bit sorted);
		int          pts [$];
		int          base;
		bit          narrow;
		logic [15:0] opa;
		pts    = {};
		narrow = $urandom_range(0, 1);
		base   = $urandom;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 7) == 0)
				pts.push_back(pts[i-1]);
			else if (narrow)
				pts.push_back(int'(base + $urandom_range(0, 32'h0004_0000)));
			else
				pts.push_back($urandom);
		end
		if (sorted)
			pts.sort();
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: opa = 16'h0000;
				1: opa = 16'hFFFF;
				default: opa = OPA_W'($urandom);
			endcase
			send_item(make_load(IDX_W'(i), pts[i], opa));
		end
	endtask

	logic [CNT_W-1:0] phase_count [NUM_PHASES] = '{16, 1, 0, 31, 3, 16, 2, 8, 5, 16};
	bit               phase_sorted [NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1, 0, 1};

	initial begin
		model = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two points at the reset count
		send_item(make_load(4'd0, 32'sh8000_0000, 16'hFFFF));
		send_item(make_load(4'd1, 32'sh7FFF_FFFF, 16'h0000));
		send_item(make_map(32'sh0000_0000, 1'b1, 1'b0));
		send_item(make_map(32'sh8000_0000, 1'b1, 1'b0));
		send_item(make_map(32'sh7FFF_FFFF, 1'b1, 1'b1));
		send_item(make_map(32'sh1234_5678, 1'b0, 1'b1));
		send_item(make_map(-32'sd1, 1'b1, 1'b1));
		// coincident points
		send_item(make_load(4'd0, 32'sh0001_0000, 16'h1000));
		send_item(make_load(4'd1, 32'sh0001_0000, 16'h8000));
		send_item(make_map(32'sh0001_0000, 1'b1, 1'b0));
		send_item(make_map(32'sh0000_FFFF, 1'b1, 1'b0));
		send_item(make_map(32'sh0001_0001, 1'b1, 1'b1));
		// points out of order
		send_item(make_load(4'd0, 32'sh0002_0000, 16'h0000));
		send_item(make_load(4'd1, 32'sh0001_0000, 16'hFFFF));
		send_item(make_map(32'sh0001_8000, 1'b1, 1'b0));
		// ordinary rising segment
		send_item(make_load(4'd0, -32'sh0001_0000, 16'h0100));
		send_item(make_load(4'd1, 32'sh0003_0000, 16'hFF00));
		send_item(make_map(32'sh0000_0000, 1'b1, 1'b0));
		send_item(make_map(32'sh0002_FFFF, 1'b1, 1'b1));
		send_item(make_map(-32'sh0000_FFFF, 1'b1, 1'b0));
		send_item(make_map(32'sh8000_0000, 1'b0, 1'b0));
		drain();

		// random phases, each with its own point count and table
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				phase_count[p] = CNT_W'($urandom_range(1, MAX_POINTS));
			write_point_count(phase_count[p]);
			load_table(model.points_in_use(), phase_sorted[p]);
			repeat (MAPS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0)
					send_item(make_load(IDX_W'($urandom_range(0, MAX_POINTS - 1)),
						$urandom, OPA_W'($urandom)));
				else
					send_item(make_map(pick_position(model.points_in_use()),
						($urandom_range(0, 11) != 0), ($urandom_range(0, 7) == 0)));
			end
			drain();
		end

		if (model.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
